/* rtl/assert_macros.svh */
// Assertion macros for the timer bank.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define STB_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("timer bank assertion failed");
`define STB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer bank assertion failed");
`else
`define STB_ASSERT(name, prop)
`define STB_ASSERT_NEXT(name, ante, cons)
`endif

`endif

/* rtl/stb_pkg.sv */
package stb_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int NFIRE_W     = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  timer_index;
    logic [31:0] start_count;
  } stb_in_t;

  typedef struct packed {
    logic [3:0] fired_index;
    logic       last_fired;
  } stb_out_t;

  typedef struct packed {
    logic                   en;
    logic [COUNT_WIDTH-1:0] cnt;
  } stb_cell_t;

  typedef struct packed {
    logic                   shift;
    logic                   load;
    logic                   load_cnt;
    logic                   en_val;
    logic [COUNT_WIDTH-1:0] cnt_val;
  } stb_cell_ctl_t;

endpackage

/* rtl/stb_cell.sv */
module stb_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  stb_pkg::stb_cell_ctl_t ctl,
  input  logic                  sel,
  input  stb_pkg::stb_cell_t    prev,
  output stb_pkg::stb_cell_t    cur
);

  logic                            en_r;
  logic                            en_nxt;
  logic [stb_pkg::COUNT_WIDTH-1:0] cnt_r;
  logic [stb_pkg::COUNT_WIDTH-1:0] cnt_nxt;

  always_comb begin
    en_nxt  = en_r;
    cnt_nxt = cnt_r;
    if (ctl.shift) begin
      en_nxt  = prev.en;
      cnt_nxt = prev.cnt;
    end else if (ctl.load && sel) begin
      en_nxt = ctl.en_val;
      if (ctl.load_cnt) begin
        cnt_nxt = ctl.cnt_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0;
    end else begin
      en_r <= en_nxt;
    end
    cnt_r <= cnt_nxt;
  end

  assign cur.en  = en_r;
  assign cur.cnt = cnt_r;

endmodule

/* rtl/software_timer_bank.sv */
// Start, stop and unused actions give no beat.
// A tick rotates the cell ring once through all NUM_TIMERS cells in S_TICK, then sends the
// final beat, if any timer fired, in S_FLUSH; out_stall can hold back a beat and stall the ring.
// The bank takes one item at a time and stalls new input until a tick is through.
// Synchronous active-low reset disables every timer; counts are not cleared.
`include "assert_macros.svh"

module software_timer_bank (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  stb_pkg::stb_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output stb_pkg::stb_out_t out_data
);

  typedef enum logic [1:0] {S_IDLE, S_TICK, S_FLUSH} state_t;

  state_t                          state_r;
  logic [stb_pkg::IDX_W-1:0]       slot_r;
  logic [stb_pkg::NFIRE_W-1:0]     nfire_r;
  logic                            pend_v_r;
  logic [3:0]                      pend_idx_r;
  logic                            out_valid_r;
  stb_pkg::stb_out_t               out_data_r;

  stb_pkg::stb_cell_t              cells [stb_pkg::NUM_TIMERS];
  stb_pkg::stb_cell_t              head_nxt;
  stb_pkg::stb_cell_ctl_t          ctl;
  logic [stb_pkg::COUNT_WIDTH-1:0] dec_cnt;
  logic                            fire;
  logic                            need_push;
  logic                            out_free;
  logic                            advance;
  logic                            accept;
  logic                            push_beat;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    dec_cnt = cells[stb_pkg::NUM_TIMERS-1].cnt;
    if (cells[stb_pkg::NUM_TIMERS-1].en && (dec_cnt != '0)) begin
      dec_cnt = dec_cnt - stb_pkg::COUNT_WIDTH'(1);
    end
    head_nxt.en  = cells[stb_pkg::NUM_TIMERS-1].en;
    head_nxt.cnt = dec_cnt;
  end

  assign fire      = (state_r == S_TICK) && head_nxt.en && (dec_cnt == '0) &&
                     (nfire_r < stb_pkg::NFIRE_W'(stb_pkg::MAX_RESULTS));
  assign need_push = fire && pend_v_r;
  assign advance   = (state_r == S_TICK) && !(need_push && !out_free);
  assign push_beat = (advance && need_push) ||
                     ((state_r == S_FLUSH) && pend_v_r && out_free);

  always_comb begin
    ctl.shift    = advance;
    ctl.load     = accept && (int'(in_data.timer_index) < stb_pkg::NUM_TIMERS) &&
                   ((in_data.action == stb_pkg::ACT_START) ||
                    (in_data.action == stb_pkg::ACT_STOP));
    ctl.load_cnt = (in_data.action == stb_pkg::ACT_START);
    ctl.en_val   = (in_data.action == stb_pkg::ACT_START);
    ctl.cnt_val  = stb_pkg::COUNT_WIDTH'(in_data.start_count);
  end

  for (genvar i = 0; i < stb_pkg::NUM_TIMERS; i++) begin : g_cell
    stb_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (ctl),
      .sel  (int'(in_data.timer_index) == i),
      .prev ((i == 0) ? head_nxt : cells[(i == 0) ? 0 : i-1]),
      .cur  (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= stb_pkg::IDX_W'(stb_pkg::NUM_TIMERS - 1);
      nfire_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (push_beat) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept && (in_data.action == stb_pkg::ACT_TICK)) begin
            state_r <= S_TICK;
            nfire_r <= '0;
          end
        end
        S_TICK: begin
          if (advance) begin
            if (need_push) begin
              out_data_r.fired_index <= pend_idx_r;
              out_data_r.last_fired  <= 1'b0;
            end
            if (fire) begin
              pend_v_r   <= 1'b1;
              pend_idx_r <= 4'(slot_r);
              nfire_r    <= nfire_r + stb_pkg::NFIRE_W'(1);
            end
            if (slot_r == '0) begin
              slot_r  <= stb_pkg::IDX_W'(stb_pkg::NUM_TIMERS - 1);
              state_r <= S_FLUSH;
            end else begin
              slot_r <= slot_r - stb_pkg::IDX_W'(1);
            end
          end
        end
        S_FLUSH: begin
          if (!pend_v_r) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_data_r.fired_index <= pend_idx_r;
            out_data_r.last_fired  <= 1'b1;
            pend_v_r               <= 1'b0;
            state_r                <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `STB_ASSERT(a_idle_no_pending, (state_r == S_IDLE) |-> !pend_v_r)
  `STB_ASSERT(a_idle_ring_home, (state_r == S_IDLE) |-> (slot_r == stb_pkg::IDX_W'(stb_pkg::NUM_TIMERS - 1)))
  `STB_ASSERT(a_fire_cap, nfire_r <= stb_pkg::NFIRE_W'(stb_pkg::MAX_RESULTS))
  `STB_ASSERT(a_beat_from_tick, $rose(out_valid_r) |-> ($past(state_r) != S_IDLE))
  `STB_ASSERT_NEXT(a_flush_ends, (state_r == S_FLUSH) && (!pend_v_r || out_free), state_r == S_IDLE)

endmodule
